// ===== rtl/core/tkcc_pkg.sv =====
// shared types and codes for the two-key click classifier
package tkcc_pkg;

  localparam int unsigned TICK_W = 8;
  localparam int unsigned EV_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // key line patterns (active low)
  localparam logic [1:0] LINES_BOTH     = 2'd0;
  localparam logic [1:0] LINES_A        = 2'd1;
  localparam logic [1:0] LINES_B        = 2'd2;
  localparam logic [1:0] LINES_RELEASED = 2'd3;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE      = 4'd0;
  localparam logic [EV_W-1:0] EV_A_SINGLE  = 4'd1;
  localparam logic [EV_W-1:0] EV_A_DOUBLE  = 4'd2;
  localparam logic [EV_W-1:0] EV_A_LONG    = 4'd3;
  localparam logic [EV_W-1:0] EV_B_SINGLE  = 4'd4;
  localparam logic [EV_W-1:0] EV_B_DOUBLE  = 4'd5;
  localparam logic [EV_W-1:0] EV_B_LONG    = 4'd6;
  localparam logic [EV_W-1:0] EV_AB_SINGLE = 4'd7;
  localparam logic [EV_W-1:0] EV_AB_DOUBLE = 4'd8;
  localparam logic [EV_W-1:0] EV_AB_LONG   = 4'd9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd1;

  localparam logic [TICK_W-1:0] LONG_TICKS_RST   = 8'd50;
  localparam logic [TICK_W-1:0] WINDOW_TICKS_RST = 8'd25;

  typedef enum logic [3:0] {
    PS_IDLE    = 4'd0,
    PS_QUAL_A  = 4'd1,
    PS_HELD_A  = 4'd2,
    PS_REST_A  = 4'd3,
    PS_QUAL_B  = 4'd4,
    PS_HELD_B  = 4'd5,
    PS_REST_B  = 4'd6,
    PS_QUAL_AB = 4'd7,
    PS_HELD_AB = 4'd8,
    PS_REST_AB = 4'd9
  } press_state_t;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_A    = 2'd1,
    CS_B    = 2'd2,
    CS_AB   = 2'd3
  } click_state_t;

endpackage

// ===== rtl/core/tkcc_press.sv =====
// press stage: qualifies presses and reports short and long presses
module tkcc_press
  import tkcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [1:0]        lines,
  input  logic [TICK_W-1:0] long_ticks,
  output logic [EV_W-1:0]   press_ev
);

  press_state_t      state_r, state_nxt;
  logic [TICK_W-1:0] hold_r, hold_nxt;
  logic [TICK_W-1:0] hold_inc;
  logic              released;
  logic              long_hit;

  assign hold_inc = hold_r + TICK_W'(1);
  assign released = (lines == LINES_RELEASED);
  assign long_hit = !released && (hold_inc >= long_ticks);

  always_comb begin
    state_nxt = state_r;
    hold_nxt  = hold_r;
    unique case (state_r)
      PS_IDLE: begin
        if (lines == LINES_A) begin
          state_nxt = PS_QUAL_A;
        end else if (lines == LINES_B) begin
          state_nxt = PS_QUAL_B;
        end else if (lines == LINES_BOTH) begin
          state_nxt = PS_QUAL_AB;
        end
      end
      PS_QUAL_A: begin
        if (lines == LINES_A) begin
          hold_nxt  = '0;
          state_nxt = PS_HELD_A;
        end else begin
          state_nxt = PS_IDLE;
        end
      end
      PS_QUAL_B: begin
        if (lines == LINES_B) begin
          hold_nxt  = '0;
          state_nxt = PS_HELD_B;
        end else begin
          state_nxt = PS_IDLE;
        end
      end
      PS_QUAL_AB: begin
        if (lines == LINES_BOTH) begin
          hold_nxt  = '0;
          state_nxt = PS_HELD_AB;
        end else begin
          state_nxt = PS_IDLE;
        end
      end
      // any pattern but released counts as still held
      PS_HELD_A: begin
        if (released) begin
          state_nxt = PS_IDLE;
        end else begin
          hold_nxt = hold_inc;
          if (long_hit) state_nxt = PS_REST_A;
        end
      end
      PS_HELD_B: begin
        if (released) begin
          state_nxt = PS_IDLE;
        end else begin
          hold_nxt = hold_inc;
          if (long_hit) state_nxt = PS_REST_B;
        end
      end
      PS_HELD_AB: begin
        if (released) begin
          state_nxt = PS_IDLE;
        end else begin
          hold_nxt = hold_inc;
          if (long_hit) state_nxt = PS_REST_AB;
        end
      end
      default: state_nxt = PS_IDLE;
    endcase
  end

  always_comb begin
    press_ev = EV_NONE;
    unique case (state_r)
      PS_HELD_A: begin
        if (released) press_ev = EV_A_SINGLE;
        else if (long_hit) press_ev = EV_A_LONG;
      end
      PS_HELD_B: begin
        if (released) press_ev = EV_B_SINGLE;
        else if (long_hit) press_ev = EV_B_LONG;
      end
      PS_HELD_AB: begin
        if (released) press_ev = EV_AB_SINGLE;
        else if (long_hit) press_ev = EV_AB_LONG;
      end
      default: press_ev = EV_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_IDLE;
      hold_r  <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      hold_r  <= hold_nxt;
    end
  end

  // a rest state always returns to idle on the next sample
  a_rest_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (state_r == PS_REST_A || state_r == PS_REST_B || state_r == PS_REST_AB))
    |=> (state_r == PS_IDLE))
    else $error("press stage left rest state to a non-idle state");

endmodule

// ===== rtl/core/tkcc_click.sv =====
// click stage: folds short presses into single or double presses and passes other events through while idle
module tkcc_click
  import tkcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [EV_W-1:0]   press_ev,
  input  logic [TICK_W-1:0] window_ticks,
  output logic [EV_W-1:0]   click_ev
);

  click_state_t      state_r, state_nxt;
  logic [TICK_W-1:0] win_r, win_nxt;
  logic [TICK_W-1:0] win_inc;
  logic [EV_W-1:0]   base;
  logic [EV_W-1:0]   dbl;
  logic              expired;

  assign win_inc = win_r + TICK_W'(1);
  assign expired = (win_inc >= window_ticks);

  always_comb begin
    unique case (state_r)
      CS_A: begin
        base = EV_A_SINGLE;
        dbl  = EV_A_DOUBLE;
      end
      CS_B: begin
        base = EV_B_SINGLE;
        dbl  = EV_B_DOUBLE;
      end
      CS_AB: begin
        base = EV_AB_SINGLE;
        dbl  = EV_AB_DOUBLE;
      end
      default: begin
        base = EV_NONE;
        dbl  = EV_NONE;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    win_nxt   = win_r;
    unique case (state_r)
      CS_IDLE: begin
        if (press_ev == EV_A_SINGLE) begin
          win_nxt   = '0;
          state_nxt = CS_A;
        end else if (press_ev == EV_B_SINGLE) begin
          win_nxt   = '0;
          state_nxt = CS_B;
        end else if (press_ev == EV_AB_SINGLE) begin
          win_nxt   = '0;
          state_nxt = CS_AB;
        end
      end
      default: begin
        // other events are dropped while the window runs
        if (press_ev == base) begin
          state_nxt = CS_IDLE;
        end else begin
          win_nxt = win_inc;
          if (expired) state_nxt = CS_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    click_ev = EV_NONE;
    unique case (state_r)
      CS_IDLE: begin
        if (press_ev != EV_A_SINGLE && press_ev != EV_B_SINGLE &&
            press_ev != EV_AB_SINGLE) begin
          click_ev = press_ev;
        end
      end
      default: begin
        if (press_ev == base) click_ev = dbl;
        else if (expired) click_ev = base;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      win_r   <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
    end
  end

endmodule

// ===== rtl/core/tkcc_outq.sv =====
// small result queue between the click stage and the output port
module tkcc_outq
  import tkcc_pkg::*;
#(
  parameter int unsigned DEPTH = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [EV_W-1:0]            push_data,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [EV_W-1:0]            out_key_event
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [EV_W-1:0]  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  assign pop           = (count_r != '0) && !out_stall;
  assign out_valid     = (count_r != '0);
  assign out_key_event = mem_r[rd_ptr_r];
  assign count         = count_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (!push && pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop) rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_W'(DEPTH)) |-> !(push && !pop))
    else $error("result queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("result queue count out of range");

endmodule

// ===== rtl/core/two_key_click_classifier_unit.sv =====
// top level of the two-key click classifier
//
//  port group  | direction | handshake         | payload
//  in_         | input     | in_valid/in_stall | in_switch_lines[1:0]
//  out_        | output    | out_valid/stall   | out_key_event[3:0]
//  cfg_        | input     | cfg_valid/ready   | cfg_index[1:0], cfg_data[7:0]
//
// one sample per cycle while in_stall is low
// samples go to an input register, then one pass of press and click logic
// writes the result queue (OUTQ_DEPTH entries)
// in_stall rises when the queue plus the sample in flight fill OUTQ_DEPTH
// synchronous active-low reset clears both stages and loads 50 and 25
module two_key_click_classifier_unit
  import tkcc_pkg::*;
#(
  parameter int unsigned OUTQ_DEPTH = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_switch_lines,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [EV_W-1:0]      out_key_event,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data
);

  localparam int unsigned CNT_W = $clog2(OUTQ_DEPTH+1);
  localparam int unsigned SUM_W = CNT_W + 1;

  logic              s1_valid_r;
  logic [1:0]        s1_lines_r;
  logic [TICK_W-1:0] long_ticks_r;
  logic [TICK_W-1:0] window_ticks_r;
  logic [EV_W-1:0]   press_ev;
  logic [EV_W-1:0]   click_ev;
  logic [CNT_W-1:0]  q_count;
  logic [SUM_W-1:0]  pending;
  logic              in_req;

  // room is reserved for the sample in flight and for the new one
  assign pending   = SUM_W'(q_count) + SUM_W'(s1_valid_r);
  assign in_stall  = (pending >= SUM_W'(OUTQ_DEPTH));
  assign in_req    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r   <= LONG_TICKS_RST;
      window_ticks_r <= WINDOW_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LONG_TICKS:   long_ticks_r   <= cfg_data;
        CFG_WINDOW_TICKS: window_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) s1_lines_r <= in_switch_lines;
  end

  tkcc_press u_press (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_valid_r),
    .lines      (s1_lines_r),
    .long_ticks (long_ticks_r),
    .press_ev   (press_ev)
  );

  tkcc_click u_click (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_valid_r),
    .press_ev     (press_ev),
    .window_ticks (window_ticks_r),
    .click_ev     (click_ev)
  );

  tkcc_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (s1_valid_r),
    .push_data     (click_ev),
    .count         (q_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_key_event (out_key_event)
  );

  a_req_reaches_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_req |=> s1_valid_r)
    else $error("accepted request did not reach the input register");

  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (click_ev <= EV_AB_LONG))
    else $error("event code out of range");

endmodule
